[rtl/dpc_pkg.sv]
// Shared types, widths and constants for the disc position commutator.
// Used by the channel interfaces and every module of the block.
package dpc_pkg;

  localparam int unsigned ANGLE_W = 12;
  localparam int unsigned ERR_W   = 14;
  localparam int unsigned MAG_W   = 11;
  localparam int unsigned DUTY_W  = 10;
  localparam int unsigned WAIT_W  = 16;
  localparam int unsigned STAT_W  = 4;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DEG_W   = 10;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned COMM_W  = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam int unsigned PWM_MAX       = 1000;
  localparam int unsigned PWM_HALF      = 500;
  localparam int unsigned START_WAIT_US = 40000;

  localparam int unsigned WRAP_HALF      = 1800;
  localparam int unsigned FULL_TURN      = 3600;
  localparam int unsigned COMMUTE_LIMIT  = 12;
  localparam int unsigned WAIT_NEAR_US   = 30000;
  localparam int unsigned WAIT_MID_US    = 22000;
  localparam int unsigned WAIT_FAR_US    = 15000;
  localparam int unsigned SETTLE_WAIT_US = 10000;
  localparam int unsigned NEAR_TENTHS    = 100;
  localparam int unsigned MID_TENTHS     = 300;
  localparam int unsigned PHASE_STEPS    = 6;
  localparam int unsigned TENTHS_PER_DEG = 10;
  localparam int unsigned MAX_DEGREE     = 360;
  localparam int unsigned CNT_SAT        = 255;

  localparam int unsigned DUTY_STEP = PWM_MAX / PHASE_STEPS;
  localparam logic [DUTY_W-1:0] DUTY_MID  = DUTY_W'(PWM_HALF);
  localparam logic [DUTY_W-1:0] DUTY_HIGH = DUTY_W'(PWM_HALF + DUTY_STEP);
  localparam logic [DUTY_W-1:0] DUTY_LOW  = DUTY_W'(PWM_HALF - DUTY_STEP);

  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_SAMPLE = 2'd1;
  localparam logic [1:0] MODE_STOP   = 2'd2;

  localparam logic [1:0] DIR_NONE = 2'd2;

  localparam logic [STAT_W-1:0] ST_RUNNING     = 4'd0;
  localparam logic [STAT_W-1:0] ST_SETTLING    = 4'd1;
  localparam logic [STAT_W-1:0] ST_OK          = 4'd2;
  localparam logic [STAT_W-1:0] ST_BAD_TARGET  = 4'd3;
  localparam logic [STAT_W-1:0] ST_SENSOR_BAD  = 4'd4;
  localparam logic [STAT_W-1:0] ST_STOPPED     = 4'd5;
  localparam logic [STAT_W-1:0] ST_OSCILLATION = 4'd6;
  localparam logic [STAT_W-1:0] ST_STALL       = 4'd7;
  localparam logic [STAT_W-1:0] ST_TIMEOUT     = 4'd8;
  localparam logic [STAT_W-1:0] ST_IDLE        = 4'd9;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_TOL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REV     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_MS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CW_ONLY     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_POS_REVERSE = 3'd7;

  typedef struct packed {
    logic [MAG_W-1:0] angle_tolerance;
    logic [CNT_W-1:0] confirm_count;
    logic [CNT_W-1:0] max_reversals;
    logic [15:0]      stall_check_ms;
    logic [MAG_W-1:0] stall_min_change;
    logic [19:0]      move_timeout_ms;
    logic             cw_only;
    logic             positive_reverse;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [DEG_W-1:0]   target_degree;
    logic [ANGLE_W-1:0] angle_tenths;
    logic               angle_valid;
    logic [TIME_W-1:0]  now_ms;
  } item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] u_duty;
    logic [DUTY_W-1:0] v_duty;
    logic [DUTY_W-1:0] w_duty;
    logic [WAIT_W-1:0] wait_us;
    logic [STAT_W-1:0] status;
    logic              finished;
  } result_t;

  typedef struct packed {
    logic               err_pos;
    logic [MAG_W-1:0]   err_mag;
    logic [ANGLE_W-1:0] cw_left;
    logic [MAG_W-1:0]   chg_mag;
  } geom_t;

endpackage

[rtl/dpc_item_if.sv]
// Input request channel of the disc position commutator.
// Depends on dpc_pkg for field widths.
interface dpc_item_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic [dpc_pkg::DEG_W-1:0]   target_degree;
  logic [dpc_pkg::ANGLE_W-1:0] angle_tenths;
  logic                        angle_valid;
  logic [dpc_pkg::TIME_W-1:0]  now_ms;

  modport source (
    output valid, mode, target_degree, angle_tenths, angle_valid, now_ms,
    input  ready
  );
  modport sink (
    input  valid, mode, target_degree, angle_tenths, angle_valid, now_ms,
    output ready
  );
endinterface

[rtl/dpc_result_if.sv]
// Result channel of the disc position commutator.
// Depends on dpc_pkg for field widths.
interface dpc_result_if;
  logic                       valid;
  logic                       ready;
  logic [dpc_pkg::DUTY_W-1:0] u_duty;
  logic [dpc_pkg::DUTY_W-1:0] v_duty;
  logic [dpc_pkg::DUTY_W-1:0] w_duty;
  logic [dpc_pkg::WAIT_W-1:0] wait_us;
  logic [dpc_pkg::STAT_W-1:0] status;
  logic                       finished;

  modport source (
    output valid, u_duty, v_duty, w_duty, wait_us, status, finished,
    input  ready
  );
  modport sink (
    input  valid, u_duty, v_duty, w_duty, wait_us, status, finished,
    output ready
  );
endinterface

[rtl/dpc_cfg_regs.sv]
// Configuration register file, written through a plain write port.
// Depends on dpc_pkg for the register indexes and cfg_t.
module dpc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dpc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output dpc_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_tolerance  <= 11'd10;
      cfg.confirm_count    <= 8'd3;
      cfg.max_reversals    <= 8'd4;
      cfg.stall_check_ms   <= 16'd500;
      cfg.stall_min_change <= 11'd5;
      cfg.move_timeout_ms  <= 20'd10000;
      cfg.cw_only          <= 1'b0;
      cfg.positive_reverse <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        dpc_pkg::REG_ANGLE_TOL:   cfg.angle_tolerance  <= cfg_data[10:0];
        dpc_pkg::REG_CONFIRM:     cfg.confirm_count    <= cfg_data[7:0];
        dpc_pkg::REG_MAX_REV:     cfg.max_reversals    <= cfg_data[7:0];
        dpc_pkg::REG_STALL_MS:    cfg.stall_check_ms   <= cfg_data[15:0];
        dpc_pkg::REG_STALL_MIN:   cfg.stall_min_change <= cfg_data[10:0];
        dpc_pkg::REG_TIMEOUT_MS:  cfg.move_timeout_ms  <= cfg_data[19:0];
        dpc_pkg::REG_CW_ONLY:     cfg.cw_only          <= cfg_data[0];
        dpc_pkg::REG_POS_REVERSE: cfg.positive_reverse <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/dpc_geom.sv]
// Angle arithmetic: wrapped target error, clockwise remainder, progress change.
// Depends on dpc_pkg for widths, turn constants and geom_t.
module dpc_geom (
  input  logic [dpc_pkg::ANGLE_W-1:0] target_tenths,
  input  logic [dpc_pkg::ANGLE_W-1:0] angle_tenths,
  input  logic [dpc_pkg::ANGLE_W-1:0] progress_ref,
  output dpc_pkg::geom_t              geom
);

  localparam logic signed [dpc_pkg::ERR_W-1:0] HALF_S =
    dpc_pkg::ERR_W'(dpc_pkg::WRAP_HALF);
  localparam logic signed [dpc_pkg::ERR_W-1:0] TURN_S =
    dpc_pkg::ERR_W'(dpc_pkg::FULL_TURN);

  function automatic logic signed [dpc_pkg::ERR_W-1:0] wrap_diff(
    input logic [dpc_pkg::ANGLE_W-1:0] to_a,
    input logic [dpc_pkg::ANGLE_W-1:0] from_a
  );
    logic signed [dpc_pkg::ERR_W-1:0] e;
    e = $signed({2'b00, to_a}) - $signed({2'b00, from_a});
    if (e > HALF_S) begin
      e = e - TURN_S;
    end else if (e < -HALF_S) begin
      e = e + TURN_S;
    end
    return e;
  endfunction

  function automatic logic [dpc_pkg::MAG_W-1:0] abs_mag(
    input logic signed [dpc_pkg::ERR_W-1:0] e
  );
    logic signed [dpc_pkg::ERR_W-1:0] a;
    a = e[dpc_pkg::ERR_W-1] ? -e : e;
    return a[dpc_pkg::MAG_W-1:0];
  endfunction

  logic signed [dpc_pkg::ERR_W-1:0] err;
  logic signed [dpc_pkg::ERR_W-1:0] chg;
  logic signed [dpc_pkg::ERR_W-1:0] cw_raw;
  logic signed [dpc_pkg::ERR_W-1:0] cw_fix;

  always_comb begin
    err    = wrap_diff(target_tenths, angle_tenths);
    chg    = wrap_diff(angle_tenths, progress_ref);
    cw_raw = $signed({2'b00, angle_tenths}) - $signed({2'b00, target_tenths});
    if (cw_raw[dpc_pkg::ERR_W-1]) begin
      cw_fix = cw_raw + TURN_S;
    end else if (cw_raw >= TURN_S) begin
      cw_fix = cw_raw - TURN_S;
    end else begin
      cw_fix = cw_raw;
    end
    geom.err_pos = !err[dpc_pkg::ERR_W-1] && (err != '0);
    geom.err_mag = abs_mag(err);
    geom.cw_left = cw_fix[dpc_pkg::ANGLE_W-1:0];
    geom.chg_mag = abs_mag(chg);
  end

endmodule

[rtl/dpc_move_ctrl.sv]
// Move state and per-request decision: settle, commutate, or end the move.
// Depends on dpc_pkg and on dpc_geom for the angle arithmetic.
module dpc_move_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  dpc_pkg::item_t  it,
  input  dpc_pkg::cfg_t   cfg,
  output dpc_pkg::result_t res
);

  logic                          active, active_next;
  logic                          awaiting_first, awaiting_first_next;
  logic [dpc_pkg::ANGLE_W-1:0]   target_tenths, target_tenths_next;
  logic [dpc_pkg::PHASE_W-1:0]   step_phase, step_phase_next;
  logic [dpc_pkg::COMM_W-1:0]    commutations, commutations_next;
  logic [1:0]                    last_direction, last_direction_next;
  logic [dpc_pkg::CNT_W-1:0]     rev_count, rev_count_next;
  logic [dpc_pkg::CNT_W-1:0]     hit_count, hit_count_next;
  logic [dpc_pkg::TIME_W-1:0]    start_time, start_time_next;
  logic [dpc_pkg::TIME_W-1:0]    check_time, check_time_next;
  logic [dpc_pkg::ANGLE_W-1:0]   progress_ref, progress_ref_next;

  dpc_pkg::geom_t                geom;
  logic [dpc_pkg::TIME_W-1:0]    elapsed, since_check;
  logic                          timed_out, check_due, stalled;
  logic [dpc_pkg::CNT_W-1:0]     hit_inc, rev_inc;
  logic                          rev, reversal;
  logic [dpc_pkg::PHASE_W-1:0]   phase_base, phase, phase_adv;
  logic [dpc_pkg::ANGLE_W-1:0]   drive_mag;
  logic [dpc_pkg::WAIT_W-1:0]    drive_wait;
  logic [dpc_pkg::DUTY_W-1:0]    du, dv, dw;
  logic [dpc_pkg::MAG_W-1:0]     chg_mag;
  logic [dpc_pkg::DEG_W-1:0]     deg_eff;
  logic                          end_now;
  logic [dpc_pkg::STAT_W-1:0]    end_status;

  dpc_geom u_geom (
    .target_tenths (target_tenths),
    .angle_tenths  (it.angle_tenths),
    .progress_ref  (progress_ref),
    .geom          (geom)
  );

  always_comb begin
    elapsed     = it.now_ms - (awaiting_first ? it.now_ms : start_time);
    since_check = it.now_ms - (awaiting_first ? it.now_ms : check_time);
    timed_out   = elapsed >= {12'd0, cfg.move_timeout_ms};
    check_due   = since_check >= {16'd0, cfg.stall_check_ms};
    chg_mag     = awaiting_first ? '0 : geom.chg_mag;
    stalled     = check_due && (chg_mag < cfg.stall_min_change);

    hit_inc = (hit_count < dpc_pkg::CNT_W'(dpc_pkg::CNT_SAT)) ? hit_count + 1'b1 : hit_count;
    rev_inc = (rev_count < dpc_pkg::CNT_W'(dpc_pkg::CNT_SAT)) ?
              rev_count + 1'b1 : rev_count;

    rev      = cfg.cw_only ? 1'b0 :
               (geom.err_pos ? cfg.positive_reverse : !cfg.positive_reverse);
    reversal = !last_direction[1] && (rev != last_direction[0]);

    phase_base = reversal ? '0 : step_phase;
    if (rev && (phase_base != '0)) begin
      phase = dpc_pkg::PHASE_W'(dpc_pkg::PHASE_STEPS) - phase_base;
    end else begin
      phase = phase_base;
    end
    phase_adv = (phase_base + 1'b1 >= dpc_pkg::PHASE_W'(dpc_pkg::PHASE_STEPS)) ?
                '0 : phase_base + 1'b1;

    du = dpc_pkg::DUTY_MID;
    dv = dpc_pkg::DUTY_MID;
    dw = dpc_pkg::DUTY_MID;
    case (phase)
      3'd0: begin du = dpc_pkg::DUTY_HIGH; dv = dpc_pkg::DUTY_LOW; end
      3'd1: begin du = dpc_pkg::DUTY_HIGH; dw = dpc_pkg::DUTY_LOW; end
      3'd2: begin dv = dpc_pkg::DUTY_HIGH; dw = dpc_pkg::DUTY_LOW; end
      3'd3: begin du = dpc_pkg::DUTY_LOW;  dv = dpc_pkg::DUTY_HIGH; end
      3'd4: begin du = dpc_pkg::DUTY_LOW;  dw = dpc_pkg::DUTY_HIGH; end
      default: begin dv = dpc_pkg::DUTY_LOW; dw = dpc_pkg::DUTY_HIGH; end
    endcase

    drive_mag = cfg.cw_only ? geom.cw_left : {1'b0, geom.err_mag};
    if (commutations < dpc_pkg::COMM_W'(dpc_pkg::COMMUTE_LIMIT)) begin
      drive_wait = dpc_pkg::WAIT_W'(dpc_pkg::START_WAIT_US);
    end else if (drive_mag <= dpc_pkg::ANGLE_W'(dpc_pkg::NEAR_TENTHS)) begin
      drive_wait = dpc_pkg::WAIT_W'(dpc_pkg::WAIT_NEAR_US);
    end else if (drive_mag <= dpc_pkg::ANGLE_W'(dpc_pkg::MID_TENTHS)) begin
      drive_wait = dpc_pkg::WAIT_W'(dpc_pkg::WAIT_MID_US);
    end else begin
      drive_wait = dpc_pkg::WAIT_W'(dpc_pkg::WAIT_FAR_US);
    end

    deg_eff = (it.target_degree == dpc_pkg::DEG_W'(dpc_pkg::MAX_DEGREE)) ?
              '0 : it.target_degree;
  end

  always_comb begin
    active_next         = active;
    awaiting_first_next = awaiting_first;
    target_tenths_next  = target_tenths;
    step_phase_next     = step_phase;
    commutations_next   = commutations;
    last_direction_next = last_direction;
    rev_count_next      = rev_count;
    hit_count_next      = hit_count;
    start_time_next     = start_time;
    check_time_next     = check_time;
    progress_ref_next   = progress_ref;
    end_now             = 1'b0;
    end_status          = dpc_pkg::ST_RUNNING;
    res                 = '0;

    case (it.mode)
      dpc_pkg::MODE_START: begin
        if (it.target_degree > dpc_pkg::DEG_W'(dpc_pkg::MAX_DEGREE)) begin
          end_now    = 1'b1;
          end_status = dpc_pkg::ST_BAD_TARGET;
        end else begin
          active_next         = 1'b1;
          awaiting_first_next = 1'b1;
          target_tenths_next  = dpc_pkg::ANGLE_W'(deg_eff) *
                                dpc_pkg::ANGLE_W'(dpc_pkg::TENTHS_PER_DEG);
          step_phase_next     = '0;
          commutations_next   = '0;
          last_direction_next = dpc_pkg::DIR_NONE;
          rev_count_next      = '0;
          hit_count_next      = '0;
          res.status          = dpc_pkg::ST_RUNNING;
        end
      end
      dpc_pkg::MODE_STOP: begin
        active_next         = 1'b0;
        awaiting_first_next = 1'b0;
        res.status          = dpc_pkg::ST_STOPPED;
        res.finished        = active;
      end
      dpc_pkg::MODE_SAMPLE: begin
        if (!active) begin
          res.status = dpc_pkg::ST_IDLE;
        end else if (awaiting_first && !it.angle_valid) begin
          end_now    = 1'b1;
          end_status = dpc_pkg::ST_SENSOR_BAD;
        end else begin
          if (awaiting_first) begin
            awaiting_first_next = 1'b0;
            start_time_next     = it.now_ms;
            check_time_next     = it.now_ms;
            progress_ref_next   = it.angle_tenths;
          end
          if (timed_out) begin
            end_now    = 1'b1;
            end_status = dpc_pkg::ST_TIMEOUT;
          end else if (!it.angle_valid) begin
            end_now    = 1'b1;
            end_status = dpc_pkg::ST_SENSOR_BAD;
          end else if (geom.err_mag <= cfg.angle_tolerance) begin
            hit_count_next = hit_inc;
            if (hit_inc >= cfg.confirm_count) begin
              end_now    = 1'b1;
              end_status = dpc_pkg::ST_OK;
            end else begin
              res.wait_us = dpc_pkg::WAIT_W'(dpc_pkg::SETTLE_WAIT_US);
              res.status  = dpc_pkg::ST_SETTLING;
            end
          end else begin
            hit_count_next = '0;
            if (reversal) begin
              rev_count_next  = rev_inc;
              step_phase_next = '0;
            end
            if (reversal && (rev_inc >= cfg.max_reversals)) begin
              end_now    = 1'b1;
              end_status = dpc_pkg::ST_OSCILLATION;
            end else begin
              last_direction_next = {1'b0, rev};
              step_phase_next     = phase_adv;
              if (commutations < dpc_pkg::COMM_W'(dpc_pkg::COMMUTE_LIMIT)) begin
                commutations_next = commutations + 1'b1;
              end
              if (stalled) begin
                end_now    = 1'b1;
                end_status = dpc_pkg::ST_STALL;
              end else begin
                if (check_due) begin
                  progress_ref_next = it.angle_tenths;
                  check_time_next   = it.now_ms;
                end
                res.u_duty  = du;
                res.v_duty  = dv;
                res.w_duty  = dw;
                res.wait_us = drive_wait;
                res.status  = dpc_pkg::ST_RUNNING;
              end
            end
          end
        end
      end
      default: begin
        res.status = active ? dpc_pkg::ST_RUNNING : dpc_pkg::ST_IDLE;
      end
    endcase

    if (end_now) begin
      active_next         = 1'b0;
      awaiting_first_next = 1'b0;
      res                 = '0;
      res.status          = end_status;
      res.finished        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      awaiting_first <= 1'b0;
      target_tenths  <= '0;
      step_phase     <= '0;
      commutations   <= '0;
      last_direction <= dpc_pkg::DIR_NONE;
      rev_count      <= '0;
      hit_count      <= '0;
      start_time     <= '0;
      check_time     <= '0;
      progress_ref   <= '0;
    end else if (fire) begin
      active         <= active_next;
      awaiting_first <= awaiting_first_next;
      target_tenths  <= target_tenths_next;
      step_phase     <= step_phase_next;
      commutations   <= commutations_next;
      last_direction <= last_direction_next;
      rev_count      <= rev_count_next;
      hit_count      <= hit_count_next;
      start_time     <= start_time_next;
      check_time     <= check_time_next;
      progress_ref   <= progress_ref_next;
    end
  end

endmodule

[rtl/disc_position_commutator.sv]
// Top level of the disc position commutator: request register, move control, result register.
// Depends on dpc_pkg, dpc_item_if, dpc_result_if, dpc_cfg_regs and dpc_move_ctrl.
//
// Each request (start, angle sample or stop) yields exactly one result through the request and
// result registers. A new request is taken every cycle while the result side keeps draining.
// The request register feeds one pass of compare and select logic whose outcome updates the
// move state and loads the result register at the same edge, so back-to-back samples see each
// other's state. Configuration writes take effect at the next edge and belong in idle periods.
module disc_position_commutator (
  input  logic                           clk,
  input  logic                           rst,
  dpc_item_if.sink                       item,
  dpc_result_if.source                   result,
  input  logic                           cfg_we,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpc_pkg::CFG_DATA_W-1:0] cfg_data
);

  dpc_pkg::cfg_t    cfg;
  dpc_pkg::item_t   it_q;
  dpc_pkg::result_t res_comb, res_q;
  logic             it_v, res_v;
  logic             advance, fire;

  assign advance    = !res_v || result.ready;
  assign fire       = it_v && advance;
  assign item.ready = !it_v || advance;

  dpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpc_move_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .it   (it_q),
    .cfg  (cfg),
    .res  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      it_v <= 1'b0;
    end else if (item.ready) begin
      it_v <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      it_q.mode          <= item.mode;
      it_q.target_degree <= item.target_degree;
      it_q.angle_tenths  <= item.angle_tenths;
      it_q.angle_valid   <= item.angle_valid;
      it_q.now_ms        <= item.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (fire) begin
      res_v <= 1'b1;
    end else if (result.ready) begin
      res_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res_comb;
    end
  end

  assign result.valid    = res_v;
  assign result.u_duty   = res_q.u_duty;
  assign result.v_duty   = res_q.v_duty;
  assign result.w_duty   = res_q.w_duty;
  assign result.wait_us  = res_q.wait_us;
  assign result.status   = res_q.status;
  assign result.finished = res_q.finished;

endmodule
